// ===== src/pee_pkg.sv =====
// shared types and constants for the prefix expression evaluator
// no dependencies
package pee_pkg;

  localparam int WORD_W        = 32;
  localparam int DIV_STEP_BITS = 4;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ACT_OPERAND = 3'd0,
    ACT_ADD     = 3'd1,
    ACT_SUB     = 3'd2,
    ACT_MUL     = 3'd3,
    ACT_DIV     = 3'd4,
    ACT_INVALID = 3'd5,
    ACT_END     = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_LEFTOVER = 3'd2,
    ST_MISSING  = 3'd3,
    ST_DIVZERO  = 3'd4,
    ST_INVALID  = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

endpackage

// ===== src/pee_divider.sv =====
// unsigned restoring divider, DIV_STEP_BITS quotient bits per cycle
// depends on pee_pkg
module pee_divider #(
  parameter int DIVIDEND_W = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DIVIDEND_W-1:0]       dividend,
  input  logic [pee_pkg::WORD_W-1:0]  divisor,
  output logic                        done,
  output logic [DIVIDEND_W-1:0]       quotient
);
  import pee_pkg::*;

  localparam int STEPS = DIVIDEND_W / DIV_STEP_BITS;
  localparam int SW    = $clog2(STEPS + 1);

  logic                  busy;
  logic [SW-1:0]         steps_left;
  logic [DIVIDEND_W-1:0] shreg;
  logic [WORD_W-1:0]     rem;
  logic [WORD_W-1:0]     dsr;
  logic [DIVIDEND_W-1:0] shreg_next;
  logic [WORD_W-1:0]     rem_next;

  always_comb begin
    logic [WORD_W:0] trial;
    shreg_next = shreg;
    rem_next   = rem;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial      = {rem_next, shreg_next[DIVIDEND_W-1]};
      shreg_next = {shreg_next[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial         = trial - {1'b0, dsr};
        shreg_next[0] = 1'b1;
      end
      rem_next = trial[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        steps_left <= SW'(STEPS);
      end else if (busy) begin
        steps_left <= steps_left - SW'(1);
        if (steps_left == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dsr   <= divisor;
    end else if (busy) begin
      shreg <= shreg_next;
      rem   <= rem_next;
    end
  end

  assign quotient = shreg;

endmodule

// ===== src/prefix_expression_evaluator_core.sv =====
// prefix expression evaluator over a stack memory, signed fixed point
// depends on pee_pkg and pee_divider
//
// token channel: action and operand_value, taken when token_valid is high
// and token_stall is low; tokens come last token first. result channel:
// status and result_value, one transaction for each end token, taken when
// result_valid is high and result_stall is low.
// an operand is taken in idle; add and subtract pass read left, read right,
// execute and push; multiply adds a multiply state; divide waits on the
// divider at four quotient bits per cycle; end loads the result register.
// operators read both operands from the single read port of the stack
// memory, one per cycle, and write the result back in place.
// the result register holds while result_stall is high; tokens other than
// end keep flowing, an end token waits until the register is free.
// reset empties the stack and clears the latched error and the result
// channel; stack memory contents are not cleared.
module prefix_expression_evaluator_core #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              token_valid,
  output logic                              token_stall,
  input  logic [2:0]                        action,
  input  logic signed [pee_pkg::WORD_W-1:0] operand_value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output pee_pkg::status_t                  status,
  output logic signed [pee_pkg::WORD_W-1:0] result_value
);
  import pee_pkg::*;

  localparam int AW     = $clog2(STACK_DEPTH);
  localparam int CW     = $clog2(STACK_DEPTH + 1);
  localparam int DIV_W  = WORD_W + FRAC_BITS;
  localparam int DIV_WP = ((DIV_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_READ_L, S_READ_R, S_EXEC, S_MUL, S_DIV, S_PUSH, S_END
  } state_t;

  state_t  state;
  logic [CW-1:0] count;
  status_t err;
  action_t op;
  word_t   left_q;
  word_t   right_q;
  word_t   res;
  logic signed [2*WORD_W-1:0] prod;

  word_t   stack_mem [STACK_DEPTH];
  word_t   rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  word_t         wr_data;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic          token_accept;
  logic          full;

  logic [WORD_W:0]        sum_ext;
  word_t                  sum_sat;
  logic [WORD_W-1:0]      lmag;
  logic [WORD_W-1:0]      rmag;
  logic                   div_start;
  logic                   div_done;
  logic [DIV_WP-1:0]      quotient;
  logic                   div_neg;
  word_t                  div_sat;
  logic signed [2*WORD_W-1:0] prod_sh;
  word_t                  mul_sat;
  status_t                end_status;
  word_t                  end_value;

  assign cnt_m1       = count - CW'(1);
  assign cnt_m2       = count - CW'(2);
  assign full         = (count == CW'(STACK_DEPTH));
  assign token_stall  = (state != S_IDLE);
  assign token_accept = token_valid && !token_stall;

  // stack memory, one write and one registered read per cycle
  always_comb begin
    unique case (state)
      S_IDLE:   rd_addr = (action == ACT_END) ? '0 : cnt_m1[AW-1:0];
      S_READ_L: rd_addr = cnt_m2[AW-1:0];
      S_END:    rd_addr = '0;
      default:  rd_addr = cnt_m1[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = operand_value;
    if (state == S_IDLE && token_accept && action == ACT_OPERAND && err == ST_OK
        && !full) begin
      wr_en = 1'b1;
    end else if (state == S_PUSH) begin
      wr_en   = 1'b1;
      wr_addr = cnt_m2[AW-1:0];
      wr_data = res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data <= stack_mem[rd_addr];
  end

  // add and subtract with saturation
  always_comb begin
    if (op == ACT_SUB) begin
      sum_ext = {left_q[WORD_W-1], left_q} - {right_q[WORD_W-1], right_q};
    end else begin
      sum_ext = {left_q[WORD_W-1], left_q} + {right_q[WORD_W-1], right_q};
    end
    if (sum_ext[WORD_W] != sum_ext[WORD_W-1]) begin
      sum_sat = sum_ext[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      sum_sat = sum_ext[WORD_W-1:0];
    end
  end

  // multiply: floor shift then saturate
  always_comb begin
    prod_sh = prod >>> FRAC_BITS;
    if ((&prod_sh[2*WORD_W-1:WORD_W-1]) || !(|prod_sh[2*WORD_W-1:WORD_W-1])) begin
      mul_sat = prod_sh[WORD_W-1:0];
    end else begin
      mul_sat = prod_sh[2*WORD_W-1] ? WORD_MIN : WORD_MAX;
    end
  end

  // divide on magnitudes, sign and saturation applied afterwards
  assign lmag      = left_q[WORD_W-1] ? WORD_W'(-left_q) : WORD_W'(left_q);
  assign rmag      = right_q[WORD_W-1] ? WORD_W'(-right_q) : WORD_W'(right_q);
  assign div_start = (state == S_EXEC) && (op == ACT_DIV) && (right_q != '0);
  assign div_neg   = left_q[WORD_W-1] ^ right_q[WORD_W-1];

  pee_divider #(
    .DIVIDEND_W (DIV_WP)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_WP'(lmag) << FRAC_BITS),
    .divisor  (rmag),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    if (!div_neg && quotient > DIV_WP'(WORD_MAX)) begin
      div_sat = WORD_MAX;
    end else if (div_neg && quotient > DIV_WP'(unsigned'(WORD_MIN))) begin
      div_sat = WORD_MIN;
    end else if (div_neg) begin
      div_sat = -quotient[WORD_W-1:0];
    end else begin
      div_sat = quotient[WORD_W-1:0];
    end
  end

  // end of expression
  always_comb begin
    end_value = '0;
    if (err != ST_OK) begin
      end_status = err;
    end else if (count == '0) begin
      end_status = ST_EMPTY;
    end else if (count > CW'(1)) begin
      end_status = ST_LEFTOVER;
    end else begin
      end_status = ST_OK;
      end_value  = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      if (state == S_END && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (token_accept) begin
            op <= action_t'(action);
            if (action == ACT_END) begin
              state <= S_END;
            end else if (err == ST_OK) begin
              if (action == ACT_OPERAND) begin
                if (full) begin
                  err <= ST_OVERFLOW;
                end else begin
                  count <= count + CW'(1);
                end
              end else if (count < CW'(2)) begin
                err <= ST_MISSING;
              end else if (action >= ACT_INVALID) begin
                err <= ST_INVALID;
              end else begin
                state <= S_READ_L;
              end
            end
          end
        end
        S_READ_L: begin
          left_q <= rd_data;
          state  <= S_READ_R;
        end
        S_READ_R: begin
          right_q <= rd_data;
          state   <= S_EXEC;
        end
        S_EXEC: begin
          case (op)
            ACT_MUL: begin
              prod  <= left_q * right_q;
              state <= S_MUL;
            end
            ACT_DIV: begin
              if (right_q == '0) begin
                err   <= ST_DIVZERO;
                state <= S_IDLE;
              end else begin
                state <= S_DIV;
              end
            end
            default: begin
              res   <= sum_sat;
              state <= S_PUSH;
            end
          endcase
        end
        S_MUL: begin
          res   <= mul_sat;
          state <= S_PUSH;
        end
        S_DIV: begin
          if (div_done) begin
            res   <= div_sat;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          count <= cnt_m1;
          state <= S_IDLE;
        end
        S_END: begin
          if (!result_valid || !result_stall) begin
            status       <= end_status;
            result_value <= end_value;
            count        <= '0;
            err          <= ST_OK;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb_prefix_expression_evaluator_core.sv =====
`timescale 1ns / 100ps
// testbench for prefix_expression_evaluator_core: reversed prefix token streams,
// results checked against an in-bench stack evaluator in signed Q16.16
// depends on pee_pkg and the evaluator rtl
module tb_prefix_expression_evaluator_core;
  import pee_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int RANDOM_ITEMS = 950;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam logic [2:0] ACT_SPARE = 3'd7;
  localparam word_t ONE_Q = 32'sh0001_0000;

  typedef struct {
    logic [2:0] act;
    word_t      value;
  } token_item_t;

  typedef struct {
    status_t st;
    word_t   value;
  } end_report_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       token_valid = 1'b0;
  logic       token_stall;
  logic [2:0] action = ACT_OPERAND;
  word_t      operand_value = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  status_t    status;
  word_t      result_value;

  token_item_t token_feed[$];
  end_report_t awaited_results[$];
  int          feed_total = 0;
  int          fed_count = 0;
  logic        token_taken = 1'b0;
  int          quiet_cycles = 0;
  int          mismatch_count = 0;

  // evaluator state
  word_t   eval_stack[STACK_DEPTH];
  int      eval_depth = 0;
  status_t eval_error = ST_OK;

  prefix_expression_evaluator_core #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .action       (action),
    .operand_value(operand_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .result_value (result_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic word_t clamp_word(longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return v[WORD_W-1:0];
  endfunction

  task automatic push_word(word_t v);
    if (eval_depth >= STACK_DEPTH) begin
      eval_error = ST_OVERFLOW;
    end else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endtask

  task automatic evaluate_token(logic [2:0] act, word_t val);
    end_report_t outcome;
    longint      lhs;
    longint      rhs;
    longint      res;
    outcome.value = '0;
    if (act == ACT_END) begin
      if (eval_error != ST_OK) outcome.st = eval_error;
      else if (eval_depth == 0) outcome.st = ST_EMPTY;
      else if (eval_depth > 1) outcome.st = ST_LEFTOVER;
      else begin
        outcome.st    = ST_OK;
        outcome.value = eval_stack[0];
      end
      awaited_results.push_back(outcome);
      eval_depth = 0;
      eval_error = ST_OK;
    end else if (eval_error == ST_OK) begin
      if (act == ACT_OPERAND) begin
        push_word(val);
      end else if (eval_depth < 2) begin
        eval_error = ST_MISSING;
      end else if (act == ACT_INVALID || act == ACT_SPARE) begin
        eval_error = ST_INVALID;
      end else begin
        lhs = eval_stack[eval_depth-1];
        rhs = eval_stack[eval_depth-2];
        if (act == ACT_DIV && rhs == 0) begin
          eval_error = ST_DIVZERO;
        end else begin
          case (act)
            ACT_ADD: res = lhs + rhs;
            ACT_SUB: res = lhs - rhs;
            ACT_MUL: res = (lhs * rhs) >>> FRAC_BITS;
            default: res = (lhs <<< FRAC_BITS) / rhs;
          endcase
          eval_depth -= 2;
          push_word(clamp_word(res));
        end
      end
    end
  endtask

  task automatic add_token(logic [2:0] act, word_t val);
    token_item_t t;
    t.act   = act;
    t.value = val;
    token_feed.push_back(t);
  endtask

  function automatic word_t pick_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return WORD_MAX;
      2: return WORD_MIN;
      3, 4: return ($signed($urandom_range(0, 200)) - 100) <<< FRAC_BITS;
      5, 6: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      default: return $urandom();
    endcase
  endfunction

  // well-formed reversed prefix expression with n_ops operators
  task automatic add_expression(int n_ops, bit operands_first);
    int ops_left;
    int opnds_left;
    int depth;
    ops_left   = n_ops;
    opnds_left = n_ops + 1;
    depth      = 0;
    while (ops_left + opnds_left > 0) begin
      if (depth >= 2 && ops_left > 0 &&
          (opnds_left == 0 || (!operands_first && $urandom_range(1) == 1))) begin
        add_token(3'($urandom_range(ACT_ADD, ACT_DIV)), $urandom());
        ops_left--;
        depth--;
      end else begin
        add_token(ACT_OPERAND, pick_operand());
        opnds_left--;
        depth++;
      end
    end
  endtask

  task automatic add_noise(int n);
    repeat (n) begin
      if ($urandom_range(1) == 1) add_token(ACT_OPERAND, pick_operand());
      else add_token(3'($urandom_range(ACT_ADD, ACT_SPARE)), $urandom());
    end
    add_token(ACT_END, $urandom());
  endtask

  // token driver
  always @(negedge clk) begin : drive_tokens
    token_item_t nxt;
    int          send_idle;
    int          recv_idle;
    if (fed_count < feed_total / 3) begin
      send_idle = 38;
      recv_idle = 69;
    end else if (fed_count < 2 * feed_total / 3) begin
      send_idle = 69;
      recv_idle = 38;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    result_stall <= ($urandom_range(99) < recv_idle);
    if (!rst && (!token_valid || token_taken)) begin
      if (token_feed.size() > 0 && $urandom_range(99) >= send_idle) begin
        nxt = token_feed.pop_front();
        fed_count++;
        token_valid   <= 1'b1;
        action        <= nxt.act;
        operand_value <= nxt.value;
      end else begin
        token_valid <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : watch_channels
    end_report_t exp_rep;
    logic        tok_fire;
    logic        res_fire;
    if (rst) begin
      token_taken <= 1'b0;
      eval_depth = 0;
      eval_error = ST_OK;
    end else begin
      tok_fire = token_valid && !token_stall;
      res_fire = result_valid && !result_stall;
      token_taken <= tok_fire;
      quiet_cycles <= (tok_fire || res_fire) ? 0 : quiet_cycles + 1;
      if (res_fire) begin
        if (awaited_results.size() == 0) begin
          $display("%0t unexpected result: status %0d value %h",
                   $time, status, result_value);
          mismatch_count++;
        end else begin
          exp_rep = awaited_results.pop_front();
          if (status !== exp_rep.st || result_value !== exp_rep.value) begin
            $display("%0t result mismatch: expected status %0d value %h, got status %0d value %h",
                     $time, exp_rep.st, exp_rep.value, status, result_value);
            mismatch_count++;
          end
        end
      end
      if (tok_fire) evaluate_token(action, operand_value);
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin : run_test
    int directed_n;
    int pick;
    // empty expression
    add_token(ACT_END, '0);
    // add and subtract saturating both ways
    add_token(ACT_OPERAND, WORD_MAX);
    add_token(ACT_OPERAND, WORD_MAX);
    add_token(ACT_ADD, '0);
    add_token(ACT_OPERAND, WORD_MIN);
    add_token(ACT_SUB, '0);
    add_token(ACT_END, '0);
    // multiply rounding down, divide saturating
    add_token(ACT_OPERAND, 32'sd1);
    add_token(ACT_OPERAND, -32'sd1);
    add_token(ACT_MUL, '1);
    add_token(ACT_OPERAND, WORD_MIN);
    add_token(ACT_DIV, '1);
    add_token(ACT_END, '1);
    // divide by zero
    add_token(ACT_OPERAND, '0);
    add_token(ACT_OPERAND, ONE_Q * 5);
    add_token(ACT_DIV, '0);
    add_token(ACT_END, '0);
    // invalid symbol with one value reports a missing operand
    add_token(ACT_OPERAND, ONE_Q);
    add_token(ACT_INVALID, '0);
    add_token(ACT_END, '0);
    // spare action code with two values
    add_token(ACT_OPERAND, ONE_Q);
    add_token(ACT_OPERAND, -ONE_Q);
    add_token(ACT_SPARE, '0);
    add_token(ACT_END, '0);
    // leftover operands
    add_token(ACT_OPERAND, '1);
    add_token(ACT_OPERAND, 32'sh5555_aaaa);
    add_token(ACT_END, '0);
    directed_n = token_feed.size();

    // full stack used exactly, then one push too many
    add_expression(STACK_DEPTH - 1, 1'b1);
    add_token(ACT_END, $urandom());
    add_expression(STACK_DEPTH, 1'b1);
    add_token(ACT_END, $urandom());
    while (token_feed.size() < directed_n + RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        add_expression($urandom_range(0, 6), 1'b0);
        add_token(ACT_END, $urandom());
      end else if (pick < 84) begin
        add_noise($urandom_range(1, 8));
      end else if (pick < 92) begin
        add_expression($urandom_range(0, 3), 1'b0);
        add_expression($urandom_range(0, 3), 1'b0);
        add_token(ACT_END, $urandom());
      end else if (pick < 96) begin
        add_expression($urandom_range(1, 4), 1'b0);
        add_noise($urandom_range(1, 3));
      end else begin
        add_token(ACT_END, $urandom());
      end
    end
    feed_total = token_feed.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (token_feed.size() > 0 || token_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
